>>> hdl/tagged_integer_register_file_unit_defines.svh
// Assertion macros, clocked on clk and disabled during rst.
`ifndef TAGGED_INTEGER_REGISTER_FILE_UNIT_DEFINES_SVH
`define TAGGED_INTEGER_REGISTER_FILE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TIRF_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tirf check failed");
`define TIRF_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tirf check failed");
`else
`define TIRF_ASSERT_IMPL(label, pre, post)
`define TIRF_ASSERT_NEXT(label, pre, post)
`endif

`endif

>>> hdl/tirf_pkg.sv
`timescale 1ns / 1ps

package tirf_pkg;

  localparam int ADDR_W      = 6;
  localparam int ENTRIES     = 64;
  localparam int VAL_FIELD_W = 64;
  localparam int TAG_FIELD_W = 3;

  typedef struct packed {
    logic [ADDR_W-1:0]      read_addr_a;
    logic [ADDR_W-1:0]      read_addr_b;
    logic [ADDR_W-1:0]      write_addr;
    logic                   write_enable;
    logic [TAG_FIELD_W-1:0] write_tag;
    logic [VAL_FIELD_W-1:0] write_value;
    logic                   in_order_only;
    logic [ADDR_W-1:0]      debug_addr;
    logic                   debug_enable;
    logic                   debug_write;
    logic [VAL_FIELD_W-1:0] debug_value;
  } tirf_req_t;

  typedef struct packed {
    logic [VAL_FIELD_W-1:0] read_value_a;
    logic [TAG_FIELD_W-1:0] read_tag_a;
    logic [VAL_FIELD_W-1:0] read_value_b;
    logic [TAG_FIELD_W-1:0] read_tag_b;
    logic                   write_ignored;
    logic [VAL_FIELD_W-1:0] debug_read_value;
    logic [VAL_FIELD_W-1:0] return_addr_value;
    logic [VAL_FIELD_W-1:0] stack_ptr_value;
  } tirf_rsp_t;

  // one committed write: value always, tag only for core writes
  typedef struct packed {
    logic              val_we;
    logic              tag_we;
    logic [ADDR_W-1:0] addr;
  } tirf_wr_t;

endpackage

>>> hdl/tirf_ram.sv
`timescale 1ns / 1ps

module tirf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/tirf_bank.sv
`timescale 1ns / 1ps

module tirf_bank #(
  parameter int DATA_WIDTH = 64,
  parameter int TAG_WIDTH  = 3,
  parameter int RA_INDEX   = 1,
  parameter int SP_INDEX   = 2
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [tirf_pkg::ADDR_W-1:0] rd_addr_a,
  input  logic [tirf_pkg::ADDR_W-1:0] rd_addr_b,
  input  logic [tirf_pkg::ADDR_W-1:0] rd_addr_d,
  input  logic [tirf_pkg::ADDR_W-1:0] rd_addr_w,
  input  logic [tirf_pkg::ADDR_W-1:0] cur_addr_a,
  input  logic [tirf_pkg::ADDR_W-1:0] cur_addr_b,
  input  logic [tirf_pkg::ADDR_W-1:0] cur_addr_d,
  input  logic [tirf_pkg::ADDR_W-1:0] cur_addr_w,
  input  tirf_pkg::tirf_wr_t        wr,
  input  logic [DATA_WIDTH-1:0]     wr_value,
  input  logic [TAG_WIDTH-1:0]      wr_tag,
  output logic [DATA_WIDTH-1:0]     val_a,
  output logic [DATA_WIDTH-1:0]     val_b,
  output logic [DATA_WIDTH-1:0]     val_d,
  output logic [DATA_WIDTH-1:0]     val_ra,
  output logic [DATA_WIDTH-1:0]     val_sp,
  output logic [TAG_WIDTH-1:0]      tag_a,
  output logic [TAG_WIDTH-1:0]      tag_b,
  output logic [TAG_WIDTH-1:0]      tag_w
);

  import tirf_pkg::*;

  localparam logic [ADDR_W-1:0] RA_ADDR = ADDR_W'(RA_INDEX);
  localparam logic [ADDR_W-1:0] SP_ADDR = ADDR_W'(SP_INDEX);

  logic [ENTRIES-1:0]    val_ok;
  logic [ENTRIES-1:0]    tag_ok;
  logic                  fwd_val_ok;
  logic                  fwd_tag_ok;
  logic [ADDR_W-1:0]     fwd_addr;
  logic [DATA_WIDTH-1:0] fwd_value;
  logic [TAG_WIDTH-1:0]  fwd_tag;
  logic [DATA_WIDTH-1:0] ra_reg;
  logic [DATA_WIDTH-1:0] sp_reg;

  logic [DATA_WIDTH-1:0] ram_a, ram_b, ram_d;
  logic [TAG_WIDTH-1:0]  tram_a, tram_b, tram_w;

  tirf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_val_a (
    .clk(clk), .we(wr.val_we), .waddr(wr.addr), .wdata(wr_value),
    .re(rd_en), .raddr(rd_addr_a), .rdata(ram_a)
  );
  tirf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_val_b (
    .clk(clk), .we(wr.val_we), .waddr(wr.addr), .wdata(wr_value),
    .re(rd_en), .raddr(rd_addr_b), .rdata(ram_b)
  );
  tirf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_val_d (
    .clk(clk), .we(wr.val_we), .waddr(wr.addr), .wdata(wr_value),
    .re(rd_en), .raddr(rd_addr_d), .rdata(ram_d)
  );
  tirf_ram #(.WIDTH(TAG_WIDTH), .DEPTH(ENTRIES)) u_tag_a (
    .clk(clk), .we(wr.tag_we), .waddr(wr.addr), .wdata(wr_tag),
    .re(rd_en), .raddr(rd_addr_a), .rdata(tram_a)
  );
  tirf_ram #(.WIDTH(TAG_WIDTH), .DEPTH(ENTRIES)) u_tag_b (
    .clk(clk), .we(wr.tag_we), .waddr(wr.addr), .wdata(wr_tag),
    .re(rd_en), .raddr(rd_addr_b), .rdata(tram_b)
  );
  tirf_ram #(.WIDTH(TAG_WIDTH), .DEPTH(ENTRIES)) u_tag_w (
    .clk(clk), .we(wr.tag_we), .waddr(wr.addr), .wdata(wr_tag),
    .re(rd_en), .raddr(rd_addr_w), .rdata(tram_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      val_ok     <= '0;
      tag_ok     <= '0;
      fwd_val_ok <= 1'b0;
      fwd_tag_ok <= 1'b0;
      ra_reg     <= '0;
      sp_reg     <= '0;
    end else if (wr.val_we) begin
      val_ok[wr.addr] <= 1'b1;
      if (wr.tag_we) begin
        tag_ok[wr.addr] <= 1'b1;
      end
      fwd_val_ok <= 1'b1;
      fwd_tag_ok <= wr.tag_we;
      if (wr.addr == RA_ADDR) begin
        ra_reg <= wr_value;
      end
      if (wr.addr == SP_ADDR) begin
        sp_reg <= wr_value;
      end
    end
  end

  // last write bypasses the RAM read taken on the same edge
  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      fwd_addr  <= wr.addr;
      fwd_value <= wr_value;
      fwd_tag   <= wr_tag;
    end
  end

  function automatic logic [DATA_WIDTH-1:0] pick_val(
    input logic [ADDR_W-1:0] addr,
    input logic [DATA_WIDTH-1:0] ram
  );
    if (!val_ok[addr]) begin
      return '0;
    end else if (fwd_val_ok && fwd_addr == addr) begin
      return fwd_value;
    end
    return ram;
  endfunction

  function automatic logic [TAG_WIDTH-1:0] pick_tag(
    input logic [ADDR_W-1:0] addr,
    input logic [TAG_WIDTH-1:0] ram
  );
    if (!tag_ok[addr]) begin
      return '0;
    end else if (fwd_tag_ok && fwd_addr == addr) begin
      return fwd_tag;
    end
    return ram;
  endfunction

  assign val_a  = pick_val(cur_addr_a, ram_a);
  assign val_b  = pick_val(cur_addr_b, ram_b);
  assign val_d  = pick_val(cur_addr_d, ram_d);
  assign tag_a  = pick_tag(cur_addr_a, tram_a);
  assign tag_b  = pick_tag(cur_addr_b, tram_b);
  assign tag_w  = pick_tag(cur_addr_w, tram_w);
  assign val_ra = ra_reg;
  assign val_sp = sp_reg;

endmodule

>>> hdl/tagged_integer_register_file_unit.sv
// channel   direction  signals                    payload
// req       in         req_valid / req_ready      tirf_req_t
// rsp       out        rsp_valid / rsp_ready      tirf_rsp_t
//
// One item per cycle sustained while rsp is not stalled; a req transfer loads the
// working stage (s1); the item then moves into the rsp register, which sets rsp valid.
// The read RAMs sample at the req transfer, the write commits as the item moves
// into the rsp register; a one-entry bypass covers a write on that same edge.
// Reset clears the 128 per-entry valid bits (64 value, 64 tag) at once; no clearing pass.
// A stalled rsp holds the working stage and, through it, req_ready.
`timescale 1ns / 1ps
`include "tagged_integer_register_file_unit_defines.svh"

module tagged_integer_register_file_unit #(
  parameter int DATA_WIDTH = 64,
  parameter int TAG_WIDTH  = 3,
  parameter int RA_INDEX   = 1,
  parameter int SP_INDEX   = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  tirf_pkg::tirf_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output tirf_pkg::tirf_rsp_t rsp
);

  import tirf_pkg::*;

  logic      s1_valid;
  tirf_req_t s1;
  logic      advance;
  logic      accept;

  tirf_wr_t              wr;
  logic [DATA_WIDTH-1:0] wr_value;
  logic [TAG_WIDTH-1:0]  wr_tag;
  logic [DATA_WIDTH-1:0] val_a, val_b, val_d, val_ra, val_sp;
  logic [TAG_WIDTH-1:0]  tag_a, tag_b, tag_w;

  logic [TAG_WIDTH+TAG_FIELD_W-1:0] wtag_pad;
  logic [TAG_WIDTH+TAG_FIELD_W-1:0] tag_a_pad;
  logic [TAG_WIDTH+TAG_FIELD_W-1:0] tag_b_pad;
  logic [TAG_WIDTH-1:0]             wtag;
  logic [TAG_WIDTH-1:0]             tag_inc;
  logic                             core_req;
  logic                             in_seq;
  logic                             do_core;
  logic                             do_dbg;
  logic                             ignored;
  tirf_rsp_t                        rsp_next;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  tirf_bank #(
    .DATA_WIDTH(DATA_WIDTH),
    .TAG_WIDTH (TAG_WIDTH),
    .RA_INDEX  (RA_INDEX),
    .SP_INDEX  (SP_INDEX)
  ) u_bank (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (req.read_addr_a),
    .rd_addr_b (req.read_addr_b),
    .rd_addr_d (req.debug_addr),
    .rd_addr_w (req.write_addr),
    .cur_addr_a(s1.read_addr_a),
    .cur_addr_b(s1.read_addr_b),
    .cur_addr_d(s1.debug_addr),
    .cur_addr_w(s1.write_addr),
    .wr        (wr),
    .wr_value  (wr_value),
    .wr_tag    (wr_tag),
    .val_a     (val_a),
    .val_b     (val_b),
    .val_d     (val_d),
    .val_ra    (val_ra),
    .val_sp    (val_sp),
    .tag_a     (tag_a),
    .tag_b     (tag_b),
    .tag_w     (tag_w)
  );

  assign wtag_pad  = {{TAG_WIDTH{1'b0}}, s1.write_tag};
  assign wtag      = wtag_pad[TAG_WIDTH-1:0];
  assign tag_inc   = tag_w + TAG_WIDTH'(1);
  assign core_req  = s1.write_enable && (s1.write_addr != '0);
  assign in_seq    = (tag_inc == wtag);
  assign do_core   = core_req && (!s1.in_order_only || in_seq);
  assign do_dbg    = !do_core && s1.debug_enable && s1.debug_write && (s1.debug_addr != '0);
  assign ignored   = core_req && s1.in_order_only && !in_seq;

  always_comb begin
    wr.val_we = advance && (do_core || do_dbg);
    wr.tag_we = advance && do_core;
    wr.addr   = do_core ? s1.write_addr : s1.debug_addr;
  end

  assign wr_value = do_core ? s1.write_value[DATA_WIDTH-1:0] : s1.debug_value[DATA_WIDTH-1:0];
  assign wr_tag   = wtag;

  assign tag_a_pad = {{TAG_FIELD_W{1'b0}}, tag_a};
  assign tag_b_pad = {{TAG_FIELD_W{1'b0}}, tag_b};

  always_comb begin
    rsp_next.read_value_a      = VAL_FIELD_W'(val_a);
    rsp_next.read_tag_a        = tag_a_pad[TAG_FIELD_W-1:0];
    rsp_next.read_value_b      = VAL_FIELD_W'(val_b);
    rsp_next.read_tag_b        = tag_b_pad[TAG_FIELD_W-1:0];
    rsp_next.write_ignored     = ignored;
    rsp_next.debug_read_value  = VAL_FIELD_W'(val_d);
    rsp_next.return_addr_value = VAL_FIELD_W'(val_ra);
    rsp_next.stack_ptr_value   = VAL_FIELD_W'(val_sp);
  end

  `TIRF_ASSERT_IMPL(a_tag_needs_val, wr.tag_we, wr.val_we)
  `TIRF_ASSERT_IMPL(a_no_write_zero, wr.val_we, wr.addr != '0)
  `TIRF_ASSERT_IMPL(a_ignored_no_core, advance && ignored, !wr.tag_we)
  `TIRF_ASSERT_IMPL(a_stall_blocks, s1_valid && rsp_valid && !rsp_ready, !req_ready)
  `TIRF_ASSERT_NEXT(a_advance_fills, advance, rsp_valid)

endmodule
